### design/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// tpsd_pkg
// shared types, codes and tables of the typed packet stream deframer
// ----------------------------------------------------------------------------
`default_nettype none

package tpsd_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH       = 4;
    localparam int OFFSET_BITS       = 32;
    localparam int LENGTH_BITS       = 17;
    localparam int COUNT_BITS        = 32;
    localparam int INDEX_BITS        = 17;
    localparam int OUT_DATA_BITS     = 96;
    localparam int OUT_USED_BITS     = 92;

    localparam logic        START_MODE_RESET   = 1'b1;
    localparam logic [15:0] RESYNC_LIMIT_RESET = 16'd500;

    // configuration register indexes
    localparam logic CFG_START_MODE   = 1'b0;
    localparam logic CFG_RESYNC_LIMIT = 1'b1;

    // packet types with a length field
    localparam logic [7:0] TYPE_LEN16_A = 8'h07;
    localparam logic [7:0] TYPE_LEN16_B = 8'h08;
    localparam logic [7:0] TYPE_LEN8_A  = 8'h17;
    localparam logic [7:0] TYPE_LEN8_B  = 8'h05;

    localparam logic [16:0] IDX_LEN16_LO = 17'd17;
    localparam logic [16:0] IDX_LEN16_HI = 17'd18;
    localparam logic [16:0] IDX_LEN8_A   = 17'd9;
    localparam logic [16:0] IDX_LEN8_B   = 17'd47;

    localparam logic [7:0] MARKER_FIRST = 8'h2C;
    localparam logic [2:0] MARKER_LEN   = 3'd6;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_PACKET,
        PH_STOPPED
    } phase_t;

    typedef enum logic [1:0] {
        ST_CLEAN,
        ST_TRUNC,
        ST_STOPPED,
        ST_NO_MARKER
    } status_t;

    // one queue entry: what a single byte caused
    typedef struct packed {
        logic                   has_desc;
        logic                   has_sum;
        logic                   truncated;
        status_t                status;
        logic [OFFSET_BITS-1:0] offset;
        logic [7:0]             ptype;
        logic [LENGTH_BITS-1:0] length;
        logic [COUNT_BITS-1:0]  total;
    } event_t;

    // one result beat
    typedef struct packed {
        logic                   kind;
        logic                   last;
        status_t                status;
        logic [COUNT_BITS-1:0]  total;
        logic                   truncated;
        logic [LENGTH_BITS-1:0] length;
        logic [7:0]             ptype;
        logic [OFFSET_BITS-1:0] offset;
    } beat_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] marker_byte(input logic [2:0] idx);
        logic [7:0] val;
        unique case (idx)
            3'd0:    val = MARKER_FIRST;
            3'd1:    val = 8'h01;
            3'd2:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // base length per type, zero for an unknown type
    function automatic logic [7:0] base_length(input logic [7:0] t);
        logic [7:0] val;
        unique case (t)
            8'h03:   val = 8'd24;
            8'h04:   val = 8'd16;
            8'h05:   val = 8'd54;
            8'h07:   val = 8'd24;
            8'h08:   val = 8'd24;
            8'h0A:   val = 8'd61;
            8'h0E:   val = 8'd4;
            8'h0C:   val = 8'd3;
            8'h12:   val = 8'd16;
            8'h13:   val = 8'd16;
            8'h14:   val = 8'd4;
            8'h15:   val = 8'd44;
            8'h16:   val = 8'd52;
            8'h17:   val = 8'd16;
            8'h18:   val = 8'd16;
            8'h19:   val = 8'd16;
            8'h1B:   val = 8'd16;
            8'h1C:   val = 8'd20;
            8'h1D:   val = 8'd21;
            8'h1E:   val = 8'd160;
            8'h20:   val = 8'd4;
            8'h31:   val = 8'd4;
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### design/tpsd_front.sv
// ----------------------------------------------------------------------------
// tpsd_front
// byte parser: marker search, packet framing, event classification
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_front #(
    parameter int POSITION_BITS = tpsd_pkg::POSITION_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start_mode,
    input  wire logic [15:0]     resync_limit,
    input  wire logic            in_fire,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_eos,
    output tpsd_pkg::event_t     evt,
    output logic                 evt_push
);
    import tpsd_pkg::*;

    phase_t                   phase_reg, phase_next, phase_upd, phase_eff;
    logic [2:0]               mp_reg, mp_next, mp_upd;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] ps_reg, ps_next, ps_upd;
    logic [INDEX_BITS-1:0]    bi_reg, bi_next, bi_upd;
    logic [7:0]               ct_reg, ct_next, ct_upd;
    logic [LENGTH_BITS-1:0]   exp_reg, exp_next, exp_upd;
    logic [COUNT_BITS-1:0]    ec_reg, ec_next, ec_upd;

    logic                     stream_start;
    logic [2:0]               mp_inc;
    logic                     marker_done;
    logic [7:0]               base;
    logic                     bad_type;
    logic                     resync_ok;
    logic                     len16, len8_a, len8_b;
    logic [LENGTH_BITS-1:0]   addend;
    logic [LENGTH_BITS-1:0]   exp_sum;
    logic [INDEX_BITS-1:0]    bi_inc;
    logic                     complete_hit;
    logic                     trunc_hit;
    logic                     has_desc;
    status_t                  status;
    logic [OFFSET_BITS-1:0]   start_lo;

    // a fresh stream samples the start mode on its first byte
    assign stream_start = (pos_reg == '0) && (phase_reg == PH_SEARCH) && (mp_reg == 3'd0)
                          && (bi_reg == '0) && (ec_reg == '0);
    assign phase_eff    = stream_start ? (start_mode ? PH_SEARCH : PH_PACKET) : phase_reg;

    assign mp_inc      = (in_byte == marker_byte(mp_reg)) ? mp_reg + 3'd1
                         : ((in_byte == MARKER_FIRST) ? 3'd1 : 3'd0);
    assign marker_done = (mp_inc >= MARKER_LEN);

    assign base      = base_length(in_byte);
    assign bad_type  = (base == 8'd0);
    assign resync_ok = (ec_reg < {{(COUNT_BITS-16){1'b0}}, resync_limit});

    assign len16  = (ct_reg == TYPE_LEN16_A) || (ct_reg == TYPE_LEN16_B);
    assign len8_a = (ct_reg == TYPE_LEN8_A);
    assign len8_b = (ct_reg == TYPE_LEN8_B);

    always_comb
    begin
        addend = '0;
        priority if (len16 && bi_reg == IDX_LEN16_LO)
            addend = {{(LENGTH_BITS-8){1'b0}}, in_byte};
        else if (len16 && bi_reg == IDX_LEN16_HI)
            addend = {{(LENGTH_BITS-16){1'b0}}, in_byte, 8'h00};
        else if (len8_a && bi_reg == IDX_LEN8_A)
            addend = {{(LENGTH_BITS-8){1'b0}}, in_byte};
        else if (len8_b && bi_reg == IDX_LEN8_B)
            addend = {{(LENGTH_BITS-8){1'b0}}, in_byte};
        else
            addend = '0;
    end

    assign exp_sum = exp_reg + addend;
    assign bi_inc  = bi_reg + 1'b1;

    // next phase
    always_comb
    begin
        phase_upd = phase_eff;
        unique case (phase_eff)
            PH_SEARCH:
            begin
                if (marker_done)
                    phase_upd = PH_PACKET;
            end
            PH_PACKET:
            begin
                if (bi_reg == 17'd1 && bad_type && !resync_ok)
                    phase_upd = PH_STOPPED;
            end
            PH_STOPPED:
            begin
                phase_upd = PH_STOPPED;
            end
        endcase
        phase_next = in_eos ? PH_SEARCH : phase_upd;
    end

    // framing datapath and event
    always_comb
    begin
        mp_upd       = mp_reg;
        ps_upd       = ps_reg;
        bi_upd       = bi_reg;
        ct_upd       = ct_reg;
        exp_upd      = exp_reg;
        complete_hit = 1'b0;
        unique case (phase_eff)
            PH_SEARCH:
            begin
                mp_upd = marker_done ? 3'd0 : mp_inc;
                if (marker_done)
                    bi_upd = '0;
            end
            PH_PACKET:
            begin
                priority if (bi_reg == '0)
                begin
                    ps_upd  = pos_reg;
                    bi_upd  = 17'd1;
                    exp_upd = '0;
                end
                else if (bi_reg == 17'd1)
                begin
                    if (bad_type)
                    begin
                        if (resync_ok)
                        begin
                            ps_upd = pos_reg;
                            bi_upd = 17'd1;
                        end
                        else
                            bi_upd = '0;
                    end
                    else
                    begin
                        ct_upd  = in_byte;
                        exp_upd = {{(LENGTH_BITS-8){1'b0}}, base};
                        bi_upd  = 17'd2;
                    end
                end
                else
                begin
                    exp_upd      = exp_sum;
                    complete_hit = (bi_inc >= exp_sum);
                    bi_upd       = complete_hit ? '0 : bi_inc;
                end
            end
            PH_STOPPED:
            begin
                bi_upd = bi_reg;
            end
        endcase

        trunc_hit = in_eos && (phase_upd == PH_PACKET) && (bi_upd >= 17'd2);
        has_desc  = complete_hit || trunc_hit;
        ec_upd    = (has_desc && ec_reg != '1) ? ec_reg + 1'b1 : ec_reg;

        priority if (phase_upd == PH_STOPPED)
            status = ST_STOPPED;
        else if (phase_upd == PH_SEARCH)
            status = ST_NO_MARKER;
        else if (bi_upd != '0)
            status = ST_TRUNC;
        else
            status = ST_CLEAN;

        evt.has_desc  = has_desc;
        evt.has_sum   = in_eos;
        evt.truncated = trunc_hit;
        evt.status    = status;
        evt.offset    = start_lo;
        evt.ptype     = ct_upd;
        evt.length    = exp_upd;
        evt.total     = ec_upd;

        // the final byte returns the stream to its reset state
        pos_next = in_eos ? '0 : pos_reg + 1'b1;
        mp_next  = in_eos ? 3'd0 : mp_upd;
        ps_next  = in_eos ? '0 : ps_upd;
        bi_next  = in_eos ? '0 : bi_upd;
        ct_next  = in_eos ? 8'd0 : ct_upd;
        exp_next = in_eos ? '0 : exp_upd;
        ec_next  = in_eos ? '0 : ec_upd;
    end

    assign evt_push = in_fire && (has_desc || in_eos);

    generate
        if (POSITION_BITS >= OFFSET_BITS)
        begin : g_off_cut
            assign start_lo = ps_reg[OFFSET_BITS-1:0];
        end
        else
        begin : g_off_ext
            assign start_lo = {{(OFFSET_BITS-POSITION_BITS){1'b0}}, ps_reg};
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            mp_reg    <= 3'd0;
            pos_reg   <= '0;
            ps_reg    <= '0;
            bi_reg    <= '0;
            ct_reg    <= 8'd0;
            exp_reg   <= '0;
            ec_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            mp_reg    <= mp_next;
            pos_reg   <= pos_next;
            ps_reg    <= ps_next;
            bi_reg    <= bi_next;
            ct_reg    <= ct_next;
            exp_reg   <= exp_next;
            ec_reg    <= ec_next;
        end
    end

endmodule

`default_nettype wire

### design/tpsd_queue.sv
// ----------------------------------------------------------------------------
// tpsd_queue
// short event queue between the parser and the result emitter
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  tpsd_pkg::event_t          push_evt,
    input  wire logic                 pop,
    output tpsd_pkg::event_t          head,
    output tpsd_pkg::queue_status_t   qstat
);
    import tpsd_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    event_t              slots [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign qstat.full  = (count_reg == CNT_FULL);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ((wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1)
                              : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ((rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1)
                              : rd_ptr_reg;
        count_next  = count_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_evt;
    end

endmodule

`default_nettype wire

### design/tpsd_back.sv
// ----------------------------------------------------------------------------
// tpsd_back
// result emitter: turns queued events into descriptor and summary beats
// ----------------------------------------------------------------------------
`default_nettype none

module tpsd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  tpsd_pkg::event_t          head,
    input  tpsd_pkg::queue_status_t   qstat,
    output logic                      pop,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output tpsd_pkg::beat_t           out_beat
);
    import tpsd_pkg::*;

    logic  out_valid_reg;
    beat_t out_beat_reg;
    beat_t beat_next;
    logic  second_reg;
    logic  load, take, more, sum_beat;

    assign load     = !out_valid_reg || out_ready;
    assign take     = load && !qstat.empty;
    // descriptor first, then summary when one event holds both
    assign sum_beat = second_reg || !head.has_desc;
    assign more     = !second_reg && head.has_desc && head.has_sum;
    assign pop      = take && !more;

    always_comb
    begin
        beat_next.kind   = sum_beat;
        beat_next.last   = sum_beat;
        beat_next.total  = head.total;
        if (sum_beat)
        begin
            beat_next.status    = head.status;
            beat_next.truncated = (head.status == ST_TRUNC);
            beat_next.length    = '0;
            beat_next.ptype     = 8'd0;
            beat_next.offset    = '0;
        end
        else
        begin
            beat_next.status    = ST_CLEAN;
            beat_next.truncated = head.truncated;
            beat_next.length    = head.length;
            beat_next.ptype     = head.ptype;
            beat_next.offset    = head.offset;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= !qstat.empty;
            if (take)
                second_reg <= more;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_beat_reg <= beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

`default_nettype wire

### design/typed_packet_stream_deframer.sv
// ----------------------------------------------------------------------------
// typed_packet_stream_deframer
// cuts a byte stream into typed packets and reports one descriptor per
// packet plus a closing summary per stream
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_axis    in   s_axis_tvalid/tready   tdata: data_byte, tlast: end_of_stream
//  m_axis    out  m_axis_tvalid/tready   tdata: result fields, tuser: kind,
//                                        tlast: last
//  cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  one byte per cycle; the parser updates all framing state in the cycle the
//  beat is taken, so nothing limits input rate but the event queue
//  a byte that ends a stream may make two result beats (descriptor then
//  summary); the emitter sends one beat per cycle, while m_axis_tready is
//  high, from a four-entry queue; s_axis_tready drops only while it is full
//  reset clears all stream state and loads start_mode 1, resync_limit 500
//  cfg_ready is always high; the user must write registers only while the
//  block is idle, which the block itself does not enforce
`default_nettype none

module typed_packet_stream_deframer #(
    parameter int POSITION_BITS = tpsd_pkg::POSITION_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // end_of_stream

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] packet_offset, [39:32] packet_type, [56:40] total_length,
    // [57] truncated, [89:58] packet_total, [91:90] status, [95:92] zero
    output logic [tpsd_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic             m_axis_tuser,   // [0] kind
    output logic             m_axis_tlast,   // last

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import tpsd_pkg::*;

    // configuration registers
    logic        start_mode_reg;
    logic [15:0] resync_limit_reg;

    logic          in_fire;
    event_t        evt;
    logic          evt_push;
    event_t        head;
    queue_status_t qstat;
    logic          pop;
    beat_t         out_beat;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !qstat.full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mode_reg   <= START_MODE_RESET;
            resync_limit_reg <= RESYNC_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_START_MODE:   start_mode_reg   <= cfg_data[0];
                CFG_RESYNC_LIMIT: resync_limit_reg <= cfg_data;
            endcase
        end
    end

    // front: framing state machine, one event per byte that yields results
    tpsd_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_mode   (start_mode_reg),
        .resync_limit (resync_limit_reg),
        .in_fire      (in_fire),
        .in_byte      (s_axis_tdata),
        .in_eos       (s_axis_tlast),
        .evt          (evt),
        .evt_push     (evt_push)
    );

    // queue decouples parser from output back-pressure
    tpsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (evt_push),
        .push_evt (evt),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // back: splits events into beats and holds the output register
    tpsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_beat  (out_beat)
    );

    // pack result fields from the lowest bit up
    assign m_axis_tdata = {{(OUT_DATA_BITS-OUT_USED_BITS){1'b0}},
                           out_beat.status, out_beat.total, out_beat.truncated,
                           out_beat.length, out_beat.ptype, out_beat.offset};
    assign m_axis_tuser = out_beat.kind;
    assign m_axis_tlast = out_beat.last;

    // a summary beat is always the last one of its stream and vice versa
    a_last_is_summary : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
        else $error("last flag and summary kind disagree");

    // summary truncated flag follows its status
    a_summary_trunc : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[57] == (m_axis_tdata[91:90] == ST_TRUNC)))
        else $error("summary truncated flag does not match status");

    // descriptors carry a clean status
    a_desc_status : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[91:90] == ST_CLEAN))
        else $error("descriptor beat carries a status code");

    // no event is lost at the queue input
    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        evt_push |-> !qstat.full)
        else $error("event pushed into a full queue");

endmodule

`default_nettype wire
